// ===== sv/cstlb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cstlb_pkg
// shared types, codes and widths of the processor state table with
// least-busy selection
// ----------------------------------------------------------------------------
package cstlb_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int TICK_WIDTH_DEF = 32;

  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 4;
  localparam int STATE_W     = 3;
  localparam int CFG_W       = 5;
  localparam int OUT_TICKS_W = 32;
  localparam int TOTAL_W     = 5;
  localparam int LB_W        = 4;

  localparam logic [STATE_W-1:0] ST_OFFLINE  = 3'd0;
  localparam logic [STATE_W-1:0] ST_BOOT     = 3'd1;
  localparam logic [STATE_W-1:0] ST_STARTING = 3'd2;
  localparam logic [STATE_W-1:0] ST_ONLINE   = 3'd3;
  localparam logic [STATE_W-1:0] ST_HALTED   = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ONLINE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_HALT   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  cpu_index;
  } item_t;

  typedef struct packed {
    logic                   status;
    logic [STATE_W-1:0]     cpu_state;
    logic [OUT_TICKS_W-1:0] cpu_ticks;
    logic [TOTAL_W-1:0]     online_total;
    logic [LB_W-1:0]        least_busy;
    logic                   none_online;
  } result_t;

  // action broadcast to every cell
  typedef struct packed {
    logic                go;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  idx;
  } cmd_t;

  // control part of the scan item handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [STATE_W-1:0] sel_state;
  } link_t;

endpackage
`default_nettype wire

// ===== sv/cpu_state_table_least_busy_select_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_state_table_least_busy_select_core
// processor state table with least-busy selection, one item at a time
// steps: apply the action, launch the scan, pass it down the cell row, then done
// a new item is taken only when idle, once the scan has passed one cell per cycle
//   down the registered cell row
// done is a one-cycle strobe; the receiver cannot stall
// reset: active_cpus = 1, processor 0 boot, others offline, all ticks zero
// ----------------------------------------------------------------------------
module cpu_state_table_least_busy_select_core #(
  parameter int MAX_PROCS  = cstlb_pkg::MAX_PROCS_DEF,
  parameter int TICK_WIDTH = cstlb_pkg::TICK_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  cstlb_pkg::item_t            request,
  output logic                        done,
  output cstlb_pkg::result_t          result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cstlb_pkg::CFG_W-1:0] cfg_data
);
  import cstlb_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [6:0] PROC_LIMIT = 7'(MAX_PROCS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPLY  = 2'd1;
  localparam logic [1:0] S_LAUNCH = 2'd2;
  localparam logic [1:0] S_WAIT   = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CFG_W-1:0]    active_cpus;
  logic [ACTION_W-1:0] op_action;
  logic [INDEX_W-1:0]  op_idx;
  logic                op_in_range;
  logic                in_range;
  logic                cfg_ok;
  logic                table_init;
  logic                finish;
  cmd_t                cmd;

  link_t                 chain_ctl   [0:MAX_PROCS];
  logic [IDX_W-1:0]      chain_idx   [0:MAX_PROCS];
  logic [TICK_WIDTH-1:0] chain_best  [0:MAX_PROCS];
  logic [CNT_W-1:0]      chain_total [0:MAX_PROCS];
  logic [TICK_WIDTH-1:0] chain_sel   [0:MAX_PROCS];

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign cfg_ok     = (cfg_data != '0) && ({2'b00, cfg_data} <= PROC_LIMIT);
  assign table_init = cfg_valid && cfg_ready && cfg_ok;
  assign in_range   = ({1'b0, request.cpu_index} < active_cpus)
                   && ({3'b000, request.cpu_index} < PROC_LIMIT);
  assign finish     = (state == S_WAIT) && chain_ctl[MAX_PROCS].valid;

  assign cmd.go     = (state == S_APPLY) && op_in_range;
  assign cmd.action = op_action;
  assign cmd.idx    = op_idx;

  // scan enters the row after the action has been applied
  assign chain_ctl[0].valid     = (state == S_LAUNCH);
  assign chain_ctl[0].found     = 1'b0;
  assign chain_ctl[0].sel_state = ST_OFFLINE;
  assign chain_idx[0]           = '0;
  assign chain_best[0]          = '0;
  assign chain_total[0]         = '0;
  assign chain_sel[0]           = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      cstlb_cell #(
        .CELL_IDX   (g),
        .MAX_PROCS  (MAX_PROCS),
        .TICK_WIDTH (TICK_WIDTH)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .init          (table_init),
        .active_cpus   (active_cpus),
        .cmd           (cmd),
        .in_ctl        (chain_ctl[g]),
        .in_idx        (chain_idx[g]),
        .in_best       (chain_best[g]),
        .in_total      (chain_total[g]),
        .in_sel_ticks  (chain_sel[g]),
        .out_ctl       (chain_ctl[g+1]),
        .out_idx       (chain_idx[g+1]),
        .out_best      (chain_best[g+1]),
        .out_total     (chain_total[g+1]),
        .out_sel_ticks (chain_sel[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY:  state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT: begin
        if (chain_ctl[MAX_PROCS].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      active_cpus <= CFG_W'(1);
    end else begin
      state <= state_next;
      done  <= finish;
      if (table_init) begin
        active_cpus <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_action   <= request.action;
      op_idx      <= request.cpu_index;
      op_in_range <= in_range;
    end
    if (finish) begin
      result.status       <= !op_in_range;
      result.cpu_state    <= op_in_range ? chain_ctl[MAX_PROCS].sel_state : ST_OFFLINE;
      result.cpu_ticks    <= op_in_range ? OUT_TICKS_W'(chain_sel[MAX_PROCS]) : '0;
      result.online_total <= TOTAL_W'(chain_total[MAX_PROCS]);
      result.least_busy   <= chain_ctl[MAX_PROCS].found ? LB_W'(chain_idx[MAX_PROCS]) : '0;
      result.none_online  <= !chain_ctl[MAX_PROCS].found;
    end
  end

  a_tail_in_wait: assert property (@(posedge clk) disable iff (rst)
    chain_ctl[MAX_PROCS].valid |-> (state == S_WAIT))
    else $error("scan left the row outside the wait state");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_active_legal: assert property (@(posedge clk) disable iff (rst)
    (active_cpus != '0) && ({2'b00, active_cpus} <= PROC_LIMIT))
    else $error("active_cpus outside legal range");

  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    table_init |=> (active_cpus == $past(cfg_data)))
    else $error("valid register write not taken");

  a_none_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.none_online == (result.online_total == '0)))
    else $error("none_online disagrees with online_total");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> ((result.cpu_state == ST_OFFLINE) && (result.cpu_ticks == '0)))
    else $error("rejected item reports processor fields");

endmodule
`default_nettype wire

// ===== sv/cstlb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cstlb_cell
// one processor entry: lifecycle state and saturating tick count, plus one
// registered step of the least-busy scan
// ----------------------------------------------------------------------------
module cstlb_cell #(
  parameter int CELL_IDX   = 0,
  parameter int MAX_PROCS  = cstlb_pkg::MAX_PROCS_DEF,
  parameter int TICK_WIDTH = cstlb_pkg::TICK_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      init,
  input  logic [cstlb_pkg::CFG_W-1:0]               active_cpus,
  input  cstlb_pkg::cmd_t                           cmd,
  input  cstlb_pkg::link_t                          in_ctl,
  input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] in_idx,
  input  logic [TICK_WIDTH-1:0]                     in_best,
  input  logic [$clog2(MAX_PROCS + 1)-1:0]          in_total,
  input  logic [TICK_WIDTH-1:0]                     in_sel_ticks,
  output cstlb_pkg::link_t                          out_ctl,
  output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] out_idx,
  output logic [TICK_WIDTH-1:0]                     out_best,
  output logic [$clog2(MAX_PROCS + 1)-1:0]          out_total,
  output logic [TICK_WIDTH-1:0]                     out_sel_ticks
);
  import cstlb_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [6:0] CELL_ID = 7'(CELL_IDX);
  localparam logic [STATE_W-1:0] ST_RESET = (CELL_IDX == 0) ? ST_BOOT : ST_OFFLINE;

  logic [STATE_W-1:0]    proc_state;
  logic [TICK_WIDTH-1:0] ticks;
  logic                  hit;
  logic                  active;
  logic                  avail;
  logic                  better;

  assign hit    = ({3'b000, cmd.idx} == CELL_ID);
  assign active = (CELL_ID < {2'b00, active_cpus});
  assign avail  = active && ((proc_state == ST_BOOT) || (proc_state == ST_ONLINE));
  assign better = avail && (!in_ctl.found || (ticks < in_best));

  always_ff @(posedge clk) begin
    if (rst || init) begin
      proc_state <= ST_RESET;
      ticks      <= '0;
    end else if (cmd.go && hit) begin
      case (cmd.action)
        ACT_START:  proc_state <= ST_STARTING;
        ACT_ONLINE: proc_state <= ST_ONLINE;
        ACT_HALT:   proc_state <= ST_HALTED;
        ACT_TICK: begin
          if (ticks != {TICK_WIDTH{1'b1}}) begin
            ticks <= ticks + TICK_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.found <= in_ctl.found || avail;
    out_idx       <= better ? IDX_W'(CELL_IDX) : in_idx;
    out_best      <= better ? ticks : in_best;
    out_total     <= in_total + CNT_W'(avail);
    if (hit) begin
      out_ctl.sel_state <= proc_state;
      out_sel_ticks     <= ticks;
    end else begin
      out_ctl.sel_state <= in_ctl.sel_state;
      out_sel_ticks     <= in_sel_ticks;
    end
  end

endmodule
`default_nettype wire
